### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fpn_pkg.sv
// Package for the frame peak normalizer: widths, constants, payload structs
// and the sequencer state type. No dependencies.
package fpn_pkg;

    localparam int FRAME_DEPTH_DEF = 64;
    localparam int SAMPLE_W        = 32;
    localparam int LEVEL_W         = 16;
    localparam int PAD_W           = 7;
    localparam int SCALE_W         = 16;
    localparam int DEN_W           = SAMPLE_W - 1;
    localparam int PROD_W          = DEN_W + SCALE_W;
    localparam int DIV_STEPS       = LEVEL_W;
    localparam int STEP_W          = $clog2(DIV_STEPS);

    localparam logic [PAD_W-1:0]   PAD_RESET    = 7'd64;
    localparam logic [PAD_W-1:0]   RESULT_LIMIT = 7'd64;
    localparam logic [SCALE_W-1:0] LEVEL_SCALE  = 16'd65000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'd65000;
    localparam logic signed [SAMPLE_W-1:0] MAX_RESET = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               run_end;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_SCALE,
        ST_DIVSTART,
        ST_DIVWAIT,
        ST_OUT
    } t_state;

endpackage

### hw/rtl/fpn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/fpn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fpn_pkg. Quotient must fit LEVEL_W bits (num < den * 2^LEVEL_W).
module fpn_div
    import fpn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [LEVEL_W-1:0] o_quo
);

    logic [DEN_W-1:0]   r_rem,  n_rem;
    logic [LEVEL_W-1:0] r_sh,   n_sh;
    logic [DEN_W-1:0]   r_den,  n_den;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DEN_W:0]     w_trial;
    logic [DEN_W+1:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_sh[LEVEL_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        n_rem   = r_rem;
        n_sh    = r_sh;
        n_den   = r_den;
        n_step  = r_step;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            // high bits seed the remainder, low bits shift in one per step
            n_rem  = i_num[PROD_W-1:LEVEL_W];
            n_sh   = i_num[LEVEL_W-1:0];
            n_den  = i_den;
            n_step = STEP_W'(DIV_STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_diff[DEN_W+1]) begin
                n_rem = w_trial[DEN_W-1:0];
                n_sh  = {r_sh[LEVEL_W-2:0], 1'b0};
            end else begin
                n_rem = w_diff[DEN_W-1:0];
                n_sh  = {r_sh[LEVEL_W-2:0], 1'b1};
            end
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_sh  <= n_sh;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

### hw/rtl/frame_peak_normalizer.sv
// Frame peak normalizer top level: sequencer, frame store, divider.
// Depends on fpn_pkg, fpn_ram, fpn_div and assert_macros.svh.
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  ---------------------------
//  in        sink       i_in_valid / o_in_ready  i_in_data  (t_in_item)
//  out       source     o_out_valid/i_out_ready  o_out_data (t_out_item)
//  cfg       sink       i_cfg_valid/o_cfg_ready  i_cfg_data (pad length)
//
// Loading accepts one sample per cycle; the frame end starts emission of pad_length
// results with input held off. A positive sample under a positive peak goes through
// read, multiply, divider start, the divider steps, divider done and output; a stored
// non-positive sample skips the divider; padding or a non-positive peak skips the read.
// Reset is synchronous; no clearing pass, the store is only read where written.
// An output stall holds the result register and the whole sequencer.
`include "assert_macros.svh"

module frame_peak_normalizer
    import fpn_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PAD_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(FRAME_DEPTH);
    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic signed [SAMPLE_W-1:0] r_max,   n_max;
    logic [PAD_W-1:0]           r_pad,   n_pad;
    logic [PAD_W-1:0]           r_total, n_total;
    logic [PAD_W-1:0]           r_k,     n_k;
    logic [LEVEL_W-1:0]         r_level, n_level;
    logic [PROD_W-1:0]          r_prod,  n_prod;

    logic                       w_we;
    logic                       w_re;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic signed [SAMPLE_W-1:0] w_rsample;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [LEVEL_W-1:0]         w_quo;
    logic                       w_in_acc;
    logic                       w_out_acc;
    logic                       w_last;
    logic [PAD_W-1:0]           w_pad_sat;

    fpn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_data.sample),
        .i_re    (w_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rdata)
    );

    fpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (r_max[DEN_W-1:0]),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_last      = ((r_k + 1'b1) == r_total);
    assign w_rsample   = w_rdata;
    // counts above the result limit saturate
    assign w_pad_sat   = (r_pad > RESULT_LIMIT) ? RESULT_LIMIT : r_pad;
    assign o_out_data  = '{level: r_level, run_end: w_last};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_max       = r_max;
        n_pad       = r_pad;
        n_total     = r_total;
        n_k         = r_k;
        n_level     = r_level;
        n_prod      = r_prod;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_div_start = 1'b0;

        if (i_cfg_valid) begin
            n_pad = i_cfg_data;
        end

        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    // store while there is room; drop the sample otherwise
                    if (r_count < CNT_W'(FRAME_DEPTH)) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        if (i_in_data.sample > r_max) begin
                            n_max = i_in_data.sample;
                        end
                    end
                    if (i_in_data.frame_end) begin
                        n_total = w_pad_sat;
                        n_k     = '0;
                        if (w_pad_sat == '0) begin
                            // nothing to emit: clear the frame and keep loading
                            n_count = '0;
                            n_max   = MAX_RESET;
                        end else begin
                            n_state = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                // read a stored sample only when it can give a nonzero level
                if ((r_k < PAD_W'(r_count)) && (r_max > 0)) begin
                    w_re    = 1'b1;
                    n_state = ST_SCALE;
                end else begin
                    n_level = '0;
                    n_state = ST_OUT;
                end
            end
            ST_SCALE: begin
                if (w_rsample > 0) begin
                    n_prod  = PROD_W'(w_rsample[DEN_W-1:0]) * PROD_W'(LEVEL_SCALE);
                    n_state = ST_DIVSTART;
                end else begin
                    n_level = '0;
                    n_state = ST_OUT;
                end
            end
            ST_DIVSTART: begin
                w_div_start = 1'b1;
                n_state     = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (w_div_done) begin
                    n_level = w_quo;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    if (w_last) begin
                        // frame done: clear for the next one
                        n_count = '0;
                        n_max   = MAX_RESET;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_max   <= MAX_RESET;
            r_pad   <= PAD_RESET;
            r_total <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
            r_pad   <= n_pad;
            r_total <= n_total;
            r_k     <= n_k;
        end
        r_level <= n_level;
        r_prod  <= n_prod;
    end

    // Checks on the sequencer and datapath.
    `AST_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input taken during emission")
    `AST_IMP(a_level_range, i_clk, i_rst_n, o_out_valid, o_out_data.level <= LEVEL_MAX, "level above scale")
    `AST_IMP(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == ST_DIVWAIT, "stray divider done")
    `AST_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FRAME_DEPTH), "store count overflow")
    `AST_NXT(a_start_wait, i_clk, i_rst_n, w_div_start, r_state == ST_DIVWAIT, "divider start lost")

endmodule
